// File: rtl/dpks_pkg.sv
// Package for the dual parallel port block: access function codes and port constants.
// Depends on nothing; used by dual_pia_keyboard_sound_port_top.
package dpks_pkg;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LOAD  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_A_DATA = 2'd0,
		REG_A_CTRL = 2'd1,
		REG_B_DATA = 2'd2,
		REG_B_CTRL = 2'd3
	} reg_sel_t;

	localparam logic [7:0]  FLAG_KEEP    = 8'h3f;
	localparam logic [7:0]  ALL_OUT      = 8'hff;
	localparam int unsigned SEL_DATA_BIT = 2;
	localparam logic [15:0] QUIET_CYCLES = 16'd36;
	localparam logic [7:0]  MUX_ROW0     = 8'hfe;
	localparam logic [7:0]  MUX_ROW1     = 8'hfd;
	localparam logic [7:0]  MUX_ROW2     = 8'hfb;
	localparam logic [7:0]  MUX_ROW3     = 8'hf7;
	localparam int unsigned NUM_ROWS     = 4;

	function automatic logic [7:0] raise_flags(input logic [7:0] ctl);
		return (ctl & FLAG_KEEP) | {ctl[1:0], 6'b0};
	endfunction

endpackage

// File: rtl/dual_pia_keyboard_sound_port_top.sv
// Two 6821-style parallel ports with a keyboard matrix and a sound byte output; uses dpks_pkg.
// Result path: a word is taken into the input register (valid_s1 and the s1 fields), then
// done, read_data and sound_byte are registered from it.
// Throughput: one word every cycle; busy is always low, as the port state is updated from
// the input register and the next word sees the updated state.
// Reset: arst_n clears all port registers and the sound cycle stamp, and sets every
// keyboard row to all ones (no key pressed).
module dual_pia_keyboard_sound_port_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [1:0]  reg_select,
	input  logic [7:0]  wdata,
	input  logic [15:0] cycle_count,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        sound_valid,
	output logic [7:0]  sound_byte
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [1:0]  sel_s1;
	logic [7:0]  wdata_s1;
	logic [15:0] cycle_s1;

	logic [7:0]  a_data_q, a_dir_q, a_ctl_q, b_data_q, b_dir_q, b_ctl_q;
	logic [15:0] last_sound_q;
	logic [7:0]  key_rows_q [dpks_pkg::NUM_ROWS];

	logic [7:0]  a_data_d, a_dir_d, a_ctl_d, b_data_d, b_dir_d, b_ctl_d;
	logic [15:0] last_sound_d;
	logic [7:0]  rd_d, snd_d;
	logic        snd_ok_d;
	logic [16:0] quiet_diff;
	logic        quiet_ok;

	logic        done_q, sound_valid_q;
	logic [7:0]  read_data_q, sound_byte_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_s1  <= func;
			sel_s1   <= reg_select;
			wdata_s1 <= wdata;
			cycle_s1 <= cycle_count;
		end
	end

	assign quiet_diff = {1'b0, cycle_s1} - {1'b0, last_sound_q};
	assign quiet_ok   = !quiet_diff[16] && (quiet_diff[15:0] >= dpks_pkg::QUIET_CYCLES);

	always_comb begin
		a_data_d     = a_data_q;
		a_dir_d      = a_dir_q;
		a_ctl_d      = a_ctl_q;
		b_data_d     = b_data_q;
		b_dir_d      = b_dir_q;
		b_ctl_d      = b_ctl_q;
		last_sound_d = last_sound_q;
		rd_d         = 8'h00;
		snd_d        = 8'h00;
		snd_ok_d     = 1'b0;
		unique case (dpks_pkg::func_t'(func_s1))
			dpks_pkg::FUNC_WRITE: begin
				unique case (dpks_pkg::reg_sel_t'(sel_s1))
					dpks_pkg::REG_A_DATA: begin
						if (a_ctl_q[dpks_pkg::SEL_DATA_BIT]) begin
							a_data_d = wdata_s1;
							if (a_dir_q == dpks_pkg::ALL_OUT) begin
								a_ctl_d = dpks_pkg::raise_flags(a_ctl_q);
							end
						end else begin
							a_dir_d = wdata_s1;
						end
					end
					dpks_pkg::REG_A_CTRL: begin
						a_ctl_d = wdata_s1 & dpks_pkg::FLAG_KEEP;
					end
					dpks_pkg::REG_B_DATA: begin
						if (b_ctl_q[dpks_pkg::SEL_DATA_BIT]) begin
							b_data_d = wdata_s1;
							if (b_dir_q == dpks_pkg::ALL_OUT) begin
								snd_ok_d     = 1'b1;
								snd_d        = wdata_s1;
								last_sound_d = cycle_s1;
								b_ctl_d      = dpks_pkg::raise_flags(b_ctl_q);
							end
						end else begin
							b_dir_d = wdata_s1;
						end
					end
					dpks_pkg::REG_B_CTRL: begin
						b_ctl_d = wdata_s1 & dpks_pkg::FLAG_KEEP;
					end
				endcase
			end
			dpks_pkg::FUNC_READ: begin
				unique case (dpks_pkg::reg_sel_t'(sel_s1))
					dpks_pkg::REG_A_DATA: begin
						if (a_ctl_q[dpks_pkg::SEL_DATA_BIT]) begin
							rd_d = ((a_dir_q & ~a_data_q) == 8'h00) ? 8'hff : a_data_q;
						end else begin
							rd_d = a_dir_q;
						end
					end
					dpks_pkg::REG_A_CTRL: begin
						a_ctl_d = a_ctl_q & dpks_pkg::FLAG_KEEP;
						rd_d    = a_ctl_d;
					end
					dpks_pkg::REG_B_DATA: begin
						if (b_ctl_q[dpks_pkg::SEL_DATA_BIT]) begin
							unique case (a_data_q)
								dpks_pkg::MUX_ROW0: begin
									b_data_d = key_rows_q[0];
									rd_d     = key_rows_q[0];
								end
								dpks_pkg::MUX_ROW1: begin
									b_data_d = key_rows_q[1];
									rd_d     = key_rows_q[1];
								end
								dpks_pkg::MUX_ROW2: begin
									b_data_d = key_rows_q[2];
									rd_d     = key_rows_q[2];
								end
								dpks_pkg::MUX_ROW3: begin
									b_data_d = key_rows_q[3];
									rd_d     = key_rows_q[3];
								end
								default: begin
									if (b_dir_q == dpks_pkg::ALL_OUT) begin
										b_ctl_d = b_ctl_q & dpks_pkg::FLAG_KEEP;
										rd_d    = b_data_q;
									end else begin
										rd_d = ((b_data_q & ~b_dir_q) == 8'h00) ?
											8'hff : b_data_q;
									end
								end
							endcase
						end else begin
							rd_d = b_dir_q;
						end
					end
					dpks_pkg::REG_B_CTRL: begin
						if (quiet_ok) begin
							b_ctl_d = b_ctl_q & dpks_pkg::FLAG_KEEP;
						end
						rd_d = b_ctl_d;
					end
				endcase
			end
			dpks_pkg::FUNC_LOAD: begin
			end
			dpks_pkg::FUNC_NONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_data_q     <= 8'h00;
			a_dir_q      <= 8'h00;
			a_ctl_q      <= 8'h00;
			b_data_q     <= 8'h00;
			b_dir_q      <= 8'h00;
			b_ctl_q      <= 8'h00;
			last_sound_q <= 16'h0000;
			for (int i = 0; i < dpks_pkg::NUM_ROWS; i++) begin
				key_rows_q[i] <= 8'hff;
			end
			done_q        <= 1'b0;
			sound_valid_q <= 1'b0;
		end else begin
			done_q        <= valid_s1;
			sound_valid_q <= valid_s1 && snd_ok_d;
			if (valid_s1) begin
				a_data_q     <= a_data_d;
				a_dir_q      <= a_dir_d;
				a_ctl_q      <= a_ctl_d;
				b_data_q     <= b_data_d;
				b_dir_q      <= b_dir_d;
				b_ctl_q      <= b_ctl_d;
				last_sound_q <= last_sound_d;
				if (func_s1 == dpks_pkg::FUNC_LOAD) begin
					key_rows_q[sel_s1] <= wdata_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q  <= rd_d;
			sound_byte_q <= snd_d;
		end
	end

	assign done        = done_q;
	assign read_data   = read_data_q;
	assign sound_valid = sound_valid_q;
	assign sound_byte  = sound_byte_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(start, 2))
		else $error("Result word strobed without a matching accepted word.");
	assert property (@(posedge clk) disable iff (!arst_n) sound_valid |-> done)
		else $error("Sound byte flagged outside a result word.");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && sound_valid |-> read_data == 8'h00)
		else $error("A sound write returned nonzero read data.");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !sound_valid |-> sound_byte == 8'h00)
		else $error("Sound byte nonzero without a sound write.");
	assert property (@(posedge clk) disable iff (!arst_n)
		sound_valid |-> last_sound_q == $past(cycle_s1))
		else $error("Sound cycle stamp not taken from the sound write.");

endmodule
